// ===== src/mrm_pkg.sv =====
// shared constants, types and state codes for the matrix row multiplier
`default_nettype none

package mrm_pkg;

   localparam int MAX_SIZE = 8;
   localparam int IDX_W    = $clog2(MAX_SIZE);
   localparam int SIZE_W   = 4;
   localparam int ELEM_W   = 32;
   localparam int ACC_W    = 64;

   localparam logic CMD_B_WRITE = 1'b0;
   localparam logic CMD_A_ELEM  = 1'b1;

   // byte address of the size register
   localparam logic [1:0] CSR_SIZE_ADDR = 2'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_WAIT,
      ST_DRAIN
   } state_type;

   // one element of the a row travelling down the chain
   typedef struct packed {
      logic                     vld;
      logic                     first;
      logic [IDX_W-1:0]         k;
      logic signed [ELEM_W-1:0] data;
   } a_word_type;

   // controls common to every cell
   typedef struct packed {
      logic                     shift;
      logic [IDX_W-1:0]         b_row;
      logic signed [ELEM_W-1:0] b_data;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== src/matrix_row_multiply.sv =====
// top level: row buffer, cell chain, control sequencer, result register and csr port
`default_nettype none

// Square integer matrix product P = A x B, one row of P per completed row of A.
// A word with tuser 0 writes one element of B into the cell of its column. A
// word with tuser 1 stores one element of A into the row buffer; if its column
// is size_in_use-1, that word also starts a row: the buffered A row is fed into
// a chain of MAX_SIZE cells (one per column of B, each with its own 32x32
// multiplier and 64-bit accumulator), one element a cycle, in the feed state;
// the elements then ripple down the chain in the wait state; then the n results
// (n being size_in_use) are shifted out of the chain in column order, one a
// cycle while the result side keeps up. A completing word thus keeps
// req_tready low through the feed, wait and drain states, and the drain lasts
// longer while the result side stalls it. A result register sits on the
// output, so the next word is taken while the last result still waits.
// The size register lies at byte address 0; only the low four bits of a write
// count: values of 0 read back as 1 and values above MAX_SIZE as MAX_SIZE.
// Elements of A or B never written give undefined products.

module matrix_row_multiply (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // row_index[2:0], col_index[5:3], element[37:6], zeros
   input  wire logic        req_tuser,  // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // out_row[2:0], out_col[5:3], product[69:6], zeros
   output logic             rsp_tlast,  // last_of_row
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int IW = mrm_pkg::IDX_W;
   localparam int MS = mrm_pkg::MAX_SIZE;

   mrm_pkg::state_type                 state_ff, state_in;
   logic [mrm_pkg::SIZE_W-1:0]         size_ff, size_in;
   logic [IW-1:0]                      nm1_ff, nm1_in;
   logic [IW-1:0]                      row_ff, row_in;
   logic [IW-1:0]                      k_ff, k_in;
   logic [IW-1:0]                      cnt_ff, cnt_in;
   logic [IW-1:0]                      j_ff, j_in;
   logic signed [mrm_pkg::ELEM_W-1:0]  a_buf_ff [MS];

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]                      rsp_row_ff, rsp_col_ff;
   logic signed [mrm_pkg::ACC_W-1:0]   rsp_prod_ff;
   logic                               rsp_last_ff;
   logic                               rsp_load;

   logic                               req_acc;
   logic [IW-1:0]                      in_row, in_col;
   logic signed [mrm_pkg::ELEM_W-1:0]  in_elem;
   logic                               completes;
   logic                               csr_wr;
   logic [mrm_pkg::SIZE_W-1:0]         wr_val;

   mrm_pkg::cell_ctl_type              ctl;
   mrm_pkg::a_word_type                a_chain [MS+1];
   logic signed [mrm_pkg::ACC_W-1:0]   acc_chain [MS+1];
   logic [MS-1:0]                      b_we;

   assign in_row  = req_tdata[IW-1:0];
   assign in_col  = req_tdata[2*IW-1:IW];
   assign in_elem = req_tdata[2*IW+mrm_pkg::ELEM_W-1:2*IW];

   // csr port
   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(size_ff);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr == mrm_pkg::CSR_SIZE_ADDR);
   assign wr_val     = csr_pwdata[mrm_pkg::SIZE_W-1:0];

   always_comb begin
      size_in = size_ff;
      if (csr_wr) begin
         if (wr_val == '0) begin
            size_in = mrm_pkg::SIZE_W'(1);
         end else if (wr_val > mrm_pkg::SIZE_W'(MS)) begin
            size_in = mrm_pkg::SIZE_W'(MS);
         end else begin
            size_in = wr_val;
         end
      end
   end

   assign req_tready = (state_ff == mrm_pkg::ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign completes  = req_acc && (req_tuser == mrm_pkg::CMD_A_ELEM)
                       && (in_col == IW'(size_ff - mrm_pkg::SIZE_W'(1)));
   assign rsp_load   = (state_ff == mrm_pkg::ST_DRAIN) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == mrm_pkg::CMD_A_ELEM) begin
         a_buf_ff[in_col] <= in_elem;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      nm1_in   = nm1_ff;
      row_in   = row_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      case (state_ff)
         mrm_pkg::ST_IDLE: begin
            if (completes) begin
               state_in = mrm_pkg::ST_FEED;
               nm1_in   = in_col;
               row_in   = in_row;
               k_in     = '0;
            end
         end
         mrm_pkg::ST_FEED: begin
            k_in = k_ff + IW'(1);
            if (k_ff == nm1_ff) begin
               state_in = mrm_pkg::ST_WAIT;
               cnt_in   = '0;
            end
         end
         mrm_pkg::ST_WAIT: begin
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == nm1_ff) begin
               state_in = mrm_pkg::ST_DRAIN;
               j_in     = '0;
            end
         end
         mrm_pkg::ST_DRAIN: begin
            if (rsp_load) begin
               j_in = j_ff + IW'(1);
               if (j_ff == nm1_ff) begin
                  state_in = mrm_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = mrm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrm_pkg::ST_IDLE;
         size_ff  <= mrm_pkg::SIZE_W'(MS);
         k_ff     <= '0;
         cnt_ff   <= '0;
         j_ff     <= '0;
         nm1_ff   <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         j_ff     <= j_in;
         nm1_ff   <= nm1_in;
      end
      row_ff <= row_in;
   end

   // result register, refilled as soon as the waiting word leaves
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= j_ff;
         rsp_prod_ff <= acc_chain[0];
         rsp_last_ff <= (j_ff == nm1_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_prod_ff, rsp_col_ff, rsp_row_ff};

   // cell chain
   assign ctl.shift  = rsp_load;
   assign ctl.b_row  = in_row;
   assign ctl.b_data = in_elem;

   assign a_chain[0].vld   = (state_ff == mrm_pkg::ST_FEED);
   assign a_chain[0].first = (k_ff == '0);
   assign a_chain[0].k     = k_ff;
   assign a_chain[0].data  = a_buf_ff[k_ff];
   assign acc_chain[MS]    = '0;

   for (genvar c = 0; c < MS; c++) begin : g_cell
      assign b_we[c] = req_acc && (req_tuser == mrm_pkg::CMD_B_WRITE) && (in_col == IW'(c));

      mrm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .b_we    (b_we[c]),
         .a_in    (a_chain[c]),
         .a_out   (a_chain[c+1]),
         .acc_nxt (acc_chain[c+1]),
         .acc     (acc_chain[c])
      );
   end

   a_feed_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrm_pkg::ST_FEED) |-> (k_ff <= nm1_ff))
      else $error("feed index ran past the row length");

   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrm_pkg::ST_DRAIN) |-> (j_ff <= nm1_ff))
      else $error("drain index ran past the row length");

   a_last_ends_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (j_ff == nm1_ff)) |=> (state_ff == mrm_pkg::ST_IDLE) && rsp_valid_ff
                                         && rsp_last_ff)
      else $error("last result of a row did not end the row");

   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && state_ff == mrm_pkg::ST_DRAIN) |=> $stable(j_ff))
      else $error("result advanced while the output word was stalled");

endmodule

`default_nettype wire

// ===== src/mrm_cell.sv =====
// one column cell: holds a column of b, multiplies the passing a word and accumulates
`default_nettype none

module mrm_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mrm_pkg::cell_ctl_type         ctl,
   input  wire logic                          b_we,
   input  wire mrm_pkg::a_word_type           a_in,
   output mrm_pkg::a_word_type                a_out,
   input  wire logic signed [mrm_pkg::ACC_W-1:0] acc_nxt,
   output logic signed [mrm_pkg::ACC_W-1:0]   acc
);

   logic signed [mrm_pkg::ELEM_W-1:0] b_col_ff [mrm_pkg::MAX_SIZE];
   mrm_pkg::a_word_type               a_ff;
   logic signed [mrm_pkg::ACC_W-1:0]  prod_ff;
   logic signed [mrm_pkg::ACC_W-1:0]  prod_in;
   logic                              prod_vld_ff;
   logic                              prod_first_ff;
   logic signed [mrm_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mrm_pkg::ACC_W-1:0]  acc_in;

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_col_ff[ctl.b_row] <= ctl.b_data;
      end
   end

   assign prod_in = mrm_pkg::ACC_W'(a_in.data) * mrm_pkg::ACC_W'(b_col_ff[a_in.k]);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld    <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         a_ff.vld    <= a_in.vld;
         prod_vld_ff <= a_in.vld;
      end
      a_ff.first    <= a_in.first;
      a_ff.k        <= a_in.k;
      a_ff.data     <= a_in.data;
      prod_ff       <= prod_in;
      prod_first_ff <= a_in.first;
   end

   // drain shift wins over accumulation
   always_comb begin
      acc_in = acc_ff;
      if (ctl.shift) begin
         acc_in = acc_nxt;
      end else if (prod_vld_ff) begin
         acc_in = prod_first_ff ? prod_ff : acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign a_out = a_ff;
   assign acc   = acc_ff;

endmodule

`default_nettype wire

// ===== bench/matrix_row_multiply_checker.sv =====
// checker for the matrix row multiplier: tracks the stores, predicts each product row, compares
module matrix_row_multiply_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,  // row_index[2:0], col_index[5:3], element[37:6], zeros
   input  wire logic        req_tuser,  // cmd
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,  // out_row[2:0], out_col[5:3], product[69:6], zeros
   input  wire logic        rsp_tlast,  // last_of_row
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               errors,
   output int               pending
);

   typedef struct packed {
      logic [mrm_pkg::IDX_W-1:0]        row;
      logic [mrm_pkg::IDX_W-1:0]        col;
      logic signed [mrm_pkg::ACC_W-1:0] product;
      logic                             last;
   } product_word_type;

   product_word_type                  products_due[$];
   logic signed [mrm_pkg::ELEM_W-1:0] b_matrix [mrm_pkg::MAX_SIZE*mrm_pkg::MAX_SIZE];
   logic signed [mrm_pkg::ELEM_W-1:0] a_row [mrm_pkg::MAX_SIZE];
   int                                size_now;
   int                                reported;

   function automatic int clamped_size(input logic [mrm_pkg::SIZE_W-1:0] value);
      if (value == 0) return 1;
      if (value > mrm_pkg::MAX_SIZE) return mrm_pkg::MAX_SIZE;
      return int'(value);
   endfunction

   // one dot product per column of b, summed at 64 bits and left to wrap
   function automatic void queue_row_products(input logic [mrm_pkg::IDX_W-1:0] row);
      product_word_type                 word;
      logic signed [mrm_pkg::ACC_W-1:0] acc;
      logic signed [mrm_pkg::ACC_W-1:0] a_wide;
      logic signed [mrm_pkg::ACC_W-1:0] b_wide;
      for (int c = 0; c < size_now; c++) begin
         acc = '0;
         for (int k = 0; k < size_now; k++) begin
            a_wide = a_row[k];
            b_wide = b_matrix[k*mrm_pkg::MAX_SIZE + c];
            acc += a_wide * b_wide;
         end
         word.row     = row;
         word.col     = mrm_pkg::IDX_W'(c);
         word.product = acc;
         word.last    = (c == size_now - 1);
         products_due.push_back(word);
      end
   endfunction

   always @(posedge clock) begin
      product_word_type           got;
      product_word_type           want;
      logic [mrm_pkg::IDX_W-1:0]  row;
      logic [mrm_pkg::IDX_W-1:0]  col;
      logic [mrm_pkg::ELEM_W-1:0] elem;
      if (reset) begin
         size_now = mrm_pkg::MAX_SIZE;
         errors   = 0;
         reported = 0;
         products_due.delete();
      end else begin
         // results first: a word taken at this edge cannot have produced one yet
         if (rsp_tvalid && rsp_tready) begin
            got.row     = rsp_tdata[mrm_pkg::IDX_W-1:0];
            got.col     = rsp_tdata[2*mrm_pkg::IDX_W-1:mrm_pkg::IDX_W];
            got.product = rsp_tdata[2*mrm_pkg::IDX_W+mrm_pkg::ACC_W-1:2*mrm_pkg::IDX_W];
            got.last    = rsp_tlast;
            if (products_due.size() == 0) begin
               errors++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected result: row %0d col %0d product %0d last %0b",
                           got.row, got.col, got.product, got.last);
               end
            end else begin
               want = products_due.pop_front();
               if (got != want) begin
                  errors++;
                  if (reported < 10) begin
                     reported++;
                     $display("mismatch: expected row %0d col %0d product %0d last %0b",
                              want.row, want.col, want.product, want.last);
                     $display("          actual   row %0d col %0d product %0d last %0b",
                              got.row, got.col, got.product, got.last);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            row  = req_tdata[mrm_pkg::IDX_W-1:0];
            col  = req_tdata[2*mrm_pkg::IDX_W-1:mrm_pkg::IDX_W];
            elem = req_tdata[2*mrm_pkg::IDX_W+mrm_pkg::ELEM_W-1:2*mrm_pkg::IDX_W];
            if (req_tuser == mrm_pkg::CMD_B_WRITE) begin
               b_matrix[row*mrm_pkg::MAX_SIZE + col] = elem;
            end else begin
               // stored even beyond the size in use, only the last column emits
               a_row[col] = elem;
               if (int'(col) == size_now - 1)
                  queue_row_products(row);
            end
         end
         // a size write takes effect after the word taken at the same edge
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == mrm_pkg::CSR_SIZE_ADDR)
            size_now = clamped_size(csr_pwdata[mrm_pkg::SIZE_W-1:0]);
      end
      pending = products_due.size();
   end

endmodule

// ===== bench/matrix_row_multiply_tb.sv =====
// testbench top for the matrix row multiplier: clock, reset, stimulus, result side and verdict
module matrix_row_multiply_tb;

   localparam int         RANDOM_ITEMS   = 400;
   localparam int         SETTLE_CYCLES  = 40;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         HOLD_AFTER     = 50;
   localparam int         WATCHDOG_LIMIT = 3000;

   localparam logic [31:0] ELEM_MIN  = 32'h8000_0000;
   localparam logic [31:0] ELEM_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] ELEM_ONES = 32'hFFFF_FFFF;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [1:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;

   int size_cur    = mrm_pkg::MAX_SIZE;
   int items_sent  = 0;
   int send_burst  = 0;
   int idle_cycles = 0;
   bit b_written [mrm_pkg::MAX_SIZE*mrm_pkg::MAX_SIZE];
   bit a_written [mrm_pkg::MAX_SIZE];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   matrix_row_multiply u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   matrix_row_multiply_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .errors      (errors),
      .pending     (pending)
   );

   // random gap with occasional runs of back-to-back words
   function automatic int next_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         burst = $urandom_range(8, 40);
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [31:0] rand_element();
      case ($urandom_range(0, 7))
         0: return ELEM_MIN;
         1: return ELEM_MAX;
         2: return '0;
         3: return ELEM_ONES;
         default: return $urandom;
      endcase
   endfunction

   // a completing a word may only read entries that were written before
   function automatic bit can_complete(input logic [2:0] col);
      for (int k = 0; k < size_cur; k++) begin
         if (k != int'(col) && !a_written[k]) return 1'b0;
         for (int c = 0; c < size_cur; c++)
            if (!b_written[k*mrm_pkg::MAX_SIZE + c]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic send_word(input logic cmd, input logic [2:0] row, input logic [2:0] col,
                            input logic [31:0] elem);
      int gap;
      if (cmd == mrm_pkg::CMD_A_ELEM && int'(col) == size_cur - 1 && !can_complete(col))
         cmd = mrm_pkg::CMD_B_WRITE;
      gap = next_gap(send_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, elem, col, row};
      do @(posedge clock); while (!req_tready);
      if (cmd == mrm_pkg::CMD_B_WRITE)
         b_written[row*mrm_pkg::MAX_SIZE + col] = 1'b1;
      else
         a_written[col] = 1'b1;
      items_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      // the block may still be busy with a word that gives no result
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [31:0] value);
      wait_drain();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= mrm_pkg::CSR_SIZE_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (value[3:0] == 0)
         size_cur = 1;
      else if (value[3:0] > mrm_pkg::MAX_SIZE)
         size_cur = mrm_pkg::MAX_SIZE;
      else
         size_cur = value[3:0];
   endtask

   // some leading elements are left out to reuse what the buffer already holds
   task automatic send_a_row(input logic [2:0] row);
      for (int c = 0; c < size_cur - 1; c++)
         if (!a_written[c] || $urandom_range(0, 4) != 0)
            send_word(mrm_pkg::CMD_A_ELEM, row, 3'(c), rand_element());
      send_word(mrm_pkg::CMD_A_ELEM, row, 3'(size_cur - 1), rand_element());
   endtask

   // result side, with one long hold-off once the flow is under way
   initial begin
      int rsp_burst;
      int gap;
      int rsp_seen;
      bit held;
      rsp_burst = 0;
      rsp_seen  = 0;
      held      = 1'b0;
      forever begin
         if (!held && rsp_seen >= HOLD_AFTER && req_tvalid) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = next_gap(rsp_burst);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_seen++;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int          random_goal;
      logic [31:0] value;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset size: words that only fill the stores
      send_word(mrm_pkg::CMD_B_WRITE, 3'd7, 3'd7, ELEM_MAX);
      send_word(mrm_pkg::CMD_A_ELEM, 3'd0, 3'd0, ELEM_MIN);
      // zero reads back as one
      write_size(32'd0);
      send_word(mrm_pkg::CMD_B_WRITE, 3'd0, 3'd0, ELEM_MIN);
      send_word(mrm_pkg::CMD_A_ELEM, 3'd7, 3'd0, ELEM_MIN);
      send_word(mrm_pkg::CMD_A_ELEM, 3'd3, 3'd5, ELEM_ONES);
      send_word(mrm_pkg::CMD_A_ELEM, 3'd0, 3'd0, ELEM_MAX);
      send_word(mrm_pkg::CMD_B_WRITE, 3'd0, 3'd0, ELEM_ONES);
      send_word(mrm_pkg::CMD_A_ELEM, 3'd1, 3'd0, 32'd0);
      send_word(mrm_pkg::CMD_A_ELEM, 3'd2, 3'd0, 32'd1);
      write_size(32'd2);
      send_word(mrm_pkg::CMD_B_WRITE, 3'd0, 3'd0, ELEM_MIN);
      send_word(mrm_pkg::CMD_B_WRITE, 3'd0, 3'd1, ELEM_MAX);
      send_word(mrm_pkg::CMD_B_WRITE, 3'd1, 3'd0, ELEM_MIN);
      send_word(mrm_pkg::CMD_B_WRITE, 3'd1, 3'd1, ELEM_ONES);
      // column 0 sums to 2^63 and wraps
      send_word(mrm_pkg::CMD_A_ELEM, 3'd4, 3'd0, ELEM_MIN);
      send_word(mrm_pkg::CMD_A_ELEM, 3'd4, 3'd1, ELEM_MIN);
      // same completing column again, row taken from the new word
      send_word(mrm_pkg::CMD_A_ELEM, 3'd6, 3'd1, ELEM_MAX);
      send_word(mrm_pkg::CMD_A_ELEM, 3'd5, 3'd7, 32'h1234_5678);
      send_word(mrm_pkg::CMD_B_WRITE, 3'd7, 3'd0, 32'hDEAD_BEEF);

      random_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < random_goal) begin
         case ($urandom_range(0, 9))
            0: value = 32'd0;
            1: value = $urandom_range(9, 15);
            2: value = mrm_pkg::MAX_SIZE;
            3: value = 32'd1;
            default: value = $urandom_range(2, 5);
         endcase
         // upper bits of the write data are not part of the register
         if ($urandom_range(0, 3) == 0)
            value = value | ($urandom & 32'hFFFF_FFF0);
         write_size(value);
         for (int k = 0; k < size_cur; k++)
            for (int c = 0; c < size_cur; c++)
               if (!b_written[k*mrm_pkg::MAX_SIZE + c] || $urandom_range(0, 2) != 0)
                  send_word(mrm_pkg::CMD_B_WRITE, 3'(k), 3'(c), rand_element());
         repeat ($urandom_range(0, 2))
            send_word(mrm_pkg::CMD_B_WRITE, 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), rand_element());
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 4))
                  send_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                            3'($urandom_range(0, 7)), $urandom);
            send_a_row(3'($urandom_range(0, 7)));
         end
      end

      wait_drain();
      @(negedge clock);
      if (errors == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
src/mrm_pkg.sv
src/mrm_cell.sv
src/matrix_row_multiply.sv
bench/matrix_row_multiply_checker.sv
bench/matrix_row_multiply_tb.sv
